[rtl/fss_pkg.sv]
`timescale 1ns / 1ps

package fss_pkg;

  // pattern and target geometry
  localparam int unsigned PAT_BYTES = 32;
  localparam int unsigned PLEN_W    = 6;
  localparam int unsigned TLEN_W    = 12;
  localparam int unsigned RUN_W     = 6;
  localparam int unsigned SCORE_W   = 18;
  localparam int unsigned FINAL_W   = 19;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [PLEN_W-1:0] PLEN_CAP   = 6'd32;
  localparam logic [TLEN_W-1:0] TLEN_MAX   = 12'd4095;
  localparam logic [RUN_W-1:0]  RUN_MAX    = 6'd63;

  // per-byte score terms
  localparam logic [10:0] GAIN_BASE      = 11'd10;
  localparam logic [10:0] BONUS_WORD     = 11'd32;
  localparam logic [10:0] BONUS_CAMEL    = 11'd24;

  // final score constants
  localparam logic signed [FINAL_W-1:0] SCORE_EMPTY_PAT = 19'sd1000;
  localparam logic signed [FINAL_W-1:0] SCORE_NO_MATCH  = -19'sd10000;
  localparam logic signed [FINAL_W-1:0] SCORE_EXACT     = 19'sd10000;
  localparam logic signed [FINAL_W-1:0] SCORE_PREFIX    = 19'sd6000;
  localparam logic signed [FINAL_W-1:0] SCORE_CEIL      = 19'sd10000;
  localparam logic signed [FINAL_W-1:0] SCORE_FLOOR     = -19'sd20000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PLEN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT3 = 3'd4;

  // per-target running state
  typedef struct packed {
    logic [PLEN_W-1:0]         pattern_pos;
    logic signed [SCORE_W-1:0] running_score;
    logic [RUN_W-1:0]          run_length;
    logic [TLEN_W-1:0]         last_match_pos;
    logic                      any_match_seen;
    logic [TLEN_W-1:0]         target_len;
    logic [7:0]                previous_byte;
    logic                      prefix_ok;
    logic                      overflow_seen;
  } fss_state_t;

  localparam fss_state_t STATE_RST = '{
    pattern_pos:    '0,
    running_score:  '0,
    run_length:     '0,
    last_match_pos: '0,
    any_match_seen: 1'b0,
    target_len:     '0,
    previous_byte:  '0,
    prefix_ok:      1'b1,
    overflow_seen:  1'b0
  };

  // one result word
  typedef struct packed {
    logic signed [15:0] match_score;
    logic               matched;
    logic               length_overflow;
  } fss_result_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A);
  endfunction

  // space, dash, underscore, dot, slash
  function automatic logic is_sep(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h2D) || (c == 8'h5F) || (c == 8'h2E) || (c == 8'h2F);
  endfunction

  // byte select out of the packed pattern, zero past the end
  function automatic logic [7:0] pat_byte(input logic [PAT_BYTES*8-1:0] pat,
                                          input logic [PLEN_W-1:0] i);
    logic [7:0] b;
    b = '0;
    if (i < PLEN_CAP) begin
      b = pat[i[4:0]*8 +: 8];
    end
    return b;
  endfunction

endpackage

[rtl/fss_byte_step.sv]
`timescale 1ns / 1ps

module fss_byte_step (
  input  fss_pkg::fss_state_t                 st_i,
  input  logic [7:0]                          byte_i,
  input  logic                                empty_i,
  input  logic [fss_pkg::PAT_BYTES*8-1:0]     pattern_i,
  input  logic [fss_pkg::PLEN_W-1:0]          plen_i,
  output fss_pkg::fss_state_t                 st_o
);
  import fss_pkg::*;

  logic [TLEN_W-1:0] idx;
  logic [7:0]        lo;
  logic              hit;
  logic [10:0]       bonus;
  logic [10:0]       gain;
  logic [TLEN_W:0]   last_p1;
  logic [TLEN_W-1:0] gap;
  logic [13:0]       pen;

  assign idx     = st_i.target_len;
  assign lo      = to_lower(byte_i);
  assign hit     = (st_i.pattern_pos < plen_i) &&
                   (lo == to_lower(pat_byte(pattern_i, st_i.pattern_pos)));
  assign last_p1 = {1'b0, st_i.last_match_pos} + {{TLEN_W{1'b0}}, 1'b1};

  // position bonus: start, after separator, camelCase hump
  always_comb begin
    if (idx == '0) begin
      bonus = BONUS_WORD;
    end else if (is_sep(st_i.previous_byte)) begin
      bonus = BONUS_WORD;
    end else if (is_upper(byte_i) && is_lower(st_i.previous_byte)) begin
      bonus = BONUS_CAMEL;
    end else begin
      bonus = '0;
    end
  end

  // gap penalty of 3 per skipped byte
  always_comb begin
    gap = '0;
    if (st_i.any_match_seen && ({1'b0, idx} > last_p1)) begin
      gap = idx - st_i.last_match_pos - {{(TLEN_W-1){1'b0}}, 1'b1};
    end
    pen = {1'b0, gap, 1'b0} + {2'b0, gap};
  end

  assign gain = GAIN_BASE + bonus + {1'b0, st_i.run_length, 4'b0};

  // next state after one target byte
  always_comb begin
    st_o = st_i;
    if (!empty_i) begin
      if (idx < TLEN_MAX) begin
        st_o.target_len = idx + {{(TLEN_W-1){1'b0}}, 1'b1};
      end else begin
        st_o.overflow_seen = 1'b1;
      end
      if ((idx < {{(TLEN_W-PLEN_W){1'b0}}, plen_i}) &&
          (lo != to_lower(pat_byte(pattern_i, idx[PLEN_W-1:0])))) begin
        st_o.prefix_ok = 1'b0;
      end
      if (st_i.pattern_pos < plen_i) begin
        if (hit) begin
          st_o.running_score = st_i.running_score
                             + $signed({{(SCORE_W-11){1'b0}}, gain})
                             - $signed({{(SCORE_W-14){1'b0}}, pen});
          if (st_i.run_length < RUN_MAX) begin
            st_o.run_length = st_i.run_length + {{(RUN_W-1){1'b0}}, 1'b1};
          end
          st_o.last_match_pos = idx;
          st_o.any_match_seen = 1'b1;
          st_o.pattern_pos    = st_i.pattern_pos + {{(PLEN_W-1){1'b0}}, 1'b1};
        end else begin
          st_o.run_length = '0;
        end
      end
      st_o.previous_byte = byte_i;
    end
  end

endmodule

[rtl/fss_final_score.sv]
`timescale 1ns / 1ps

module fss_final_score (
  input  fss_pkg::fss_state_t        st_i,
  input  logic [fss_pkg::PLEN_W-1:0] plen_i,
  output fss_pkg::fss_result_t       res_o
);
  import fss_pkg::*;

  logic [TLEN_W-1:0]         plen_ext;
  logic signed [FINAL_W-1:0] tl_s;
  logic signed [FINAL_W-1:0] excess_s;
  logic signed [FINAL_W-1:0] rs_s;
  logic signed [FINAL_W-1:0] raw;
  logic signed [FINAL_W-1:0] sat;

  assign plen_ext = {{(TLEN_W-PLEN_W){1'b0}}, plen_i};
  assign tl_s     = $signed({{(FINAL_W-TLEN_W){1'b0}}, st_i.target_len});
  assign excess_s = $signed({{(FINAL_W-TLEN_W){1'b0}}, st_i.target_len - plen_ext});
  assign rs_s     = $signed({st_i.running_score[SCORE_W-1], st_i.running_score});

  // decision in order of precedence
  always_comb begin
    priority if (plen_i == '0) begin
      raw = SCORE_EMPTY_PAT;
    end else if (st_i.target_len == '0) begin
      raw = SCORE_NO_MATCH;
    end else if (plen_ext > st_i.target_len) begin
      raw = SCORE_NO_MATCH;
    end else if (st_i.prefix_ok && (st_i.target_len == plen_ext)) begin
      raw = SCORE_EXACT - tl_s;
    end else if (st_i.prefix_ok) begin
      raw = SCORE_PREFIX - tl_s;
    end else if (st_i.pattern_pos < plen_i) begin
      raw = SCORE_NO_MATCH;
    end else begin
      raw = rs_s - excess_s;
    end
  end

  // clamp to the output range
  always_comb begin
    priority if (raw > SCORE_CEIL) begin
      sat = SCORE_CEIL;
    end else if (raw < SCORE_FLOOR) begin
      sat = SCORE_FLOOR;
    end else begin
      sat = raw;
    end
  end

  assign res_o.match_score     = sat[15:0];
  assign res_o.matched         = (sat > SCORE_NO_MATCH);
  assign res_o.length_overflow = st_i.overflow_seen;

endmodule

[rtl/fuzzy_subsequence_score_unit.sv]
`timescale 1ns / 1ps

// fuzzy subsequence scorer for a streamed target string
// program the pattern through the write port: index 0 takes the length
// (0..63, above 32 acts as 32), indexes 1..4 take pattern bytes 8 at a time, byte 0 lowest
// target bytes enter at most one per cycle on the in channel; end_of_target
// flags the last byte, empty_target ends a target without adding a byte
// each ended target yields one word on the out channel: the score, a match
// flag and a flag for a target longer than 4095 bytes
// a word is latched in the input register, scored in one pass of logic
// against the running per-target state, and lands in the result register:
// out_valid_o rises once the closing word moves on into the result register;
// one word per cycle sustained while the receiver keeps up
// a stalled receiver holds the result register; the input register keeps
// taking one more word, then in_ready_o drops until the result is taken
// reset clears the pattern, the per-target state and both valid flags
// write the pattern only while nothing is in flight; a write in the middle
// of a target applies to the bytes that follow and to the final score
module fuzzy_subsequence_score_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fss_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [fss_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [7:0]                          target_byte_i,
  input  logic                                end_of_target_i,
  input  logic                                empty_target_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [15:0]                  match_score_o,
  output logic                                matched_o,
  output logic                                length_overflow_o
);
  import fss_pkg::*;

  logic [PLEN_W-1:0]          plen_reg_q;
  logic [PAT_BYTES*8-1:0]     pattern_q;
  logic [PLEN_W-1:0]          plen_eff;

  logic                       item_valid_q;
  logic [7:0]                 byte_q;
  logic                       eot_q;
  logic                       empty_q;

  fss_state_t                 state_q;
  fss_state_t                 state_upd;
  fss_result_t                res;
  fss_result_t                out_q;
  logic                       out_valid_q;

  logic                       adv;
  logic                       ends;
  logic                       in_fire;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_reg_q <= '0;
      pattern_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PLEN: plen_reg_q <= cfg_wdata_i[PLEN_W-1:0];
        CFG_PAT0: pattern_q[0*CFG_DATA_W +: CFG_DATA_W] <= cfg_wdata_i;
        CFG_PAT1: pattern_q[1*CFG_DATA_W +: CFG_DATA_W] <= cfg_wdata_i;
        CFG_PAT2: pattern_q[2*CFG_DATA_W +: CFG_DATA_W] <= cfg_wdata_i;
        CFG_PAT3: pattern_q[3*CFG_DATA_W +: CFG_DATA_W] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign plen_eff = (plen_reg_q > PLEN_CAP) ? PLEN_CAP : plen_reg_q;

  // handshake: advance when the result slot is free or draining
  assign adv        = item_valid_q && (!out_valid_q || out_ready_i);
  assign ends       = eot_q || empty_q;
  assign in_ready_o = !item_valid_q || adv;
  assign in_fire    = in_valid_i && in_ready_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_fire) begin
      item_valid_q <= 1'b1;
    end else if (adv) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_q  <= target_byte_i;
      eot_q   <= end_of_target_i;
      empty_q <= empty_target_i;
    end
  end

  fss_byte_step u_step (
    .st_i      (state_q),
    .byte_i    (byte_q),
    .empty_i   (empty_q),
    .pattern_i (pattern_q),
    .plen_i    (plen_eff),
    .st_o      (state_upd)
  );

  fss_final_score u_final (
    .st_i   (state_upd),
    .plen_i (plen_eff),
    .res_o  (res)
  );

  // per-target state, cleared when a target ends
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RST;
    end else if (adv) begin
      state_q <= ends ? STATE_RST : state_upd;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && ends) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && ends) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign match_score_o     = out_q.match_score;
  assign matched_o         = out_q.matched;
  assign length_overflow_o = out_q.length_overflow;

endmodule

[tb/fuzzy_score_checker.sv]
`timescale 1ns / 1ps

// watches the config port and both channels of the fuzzy scorer, predicts
// the score word of every ended target and compares it with the returned word
module fuzzy_score_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fss_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fss_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [7:0]                     target_byte_i,
  input  logic                           end_of_target_i,
  input  logic                           empty_target_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic signed [15:0]             match_score_i,
  input  logic                           matched_i,
  input  logic                           length_overflow_i,
  output int                             pending_o,
  output int                             fail_count_o
);
  import fss_pkg::*;

  // copy of the pattern registers
  logic [5:0]  pat_len_q;
  logic [63:0] pat_word_q [4];

  // per-target matching state
  int          pat_pos;
  int          run_len;
  int          last_pos;
  int          tgt_len;
  int          acc_score;
  logic        any_hit;
  logic        prefix_good;
  logic        too_long;
  logic [7:0]  prev_byte;

  // score words still owed by the scorer, oldest first
  fss_result_t owed_scores [$];

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
  endfunction

  // space, dash, underscore, dot, slash
  function automatic logic word_break(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h2D) || (c == 8'h5F) || (c == 8'h2E) || (c == 8'h2F);
  endfunction

  function automatic logic [7:0] pat_char(input int i);
    if (i >= PAT_BYTES) return 8'h00;
    return pat_word_q[i / 8][(i % 8) * 8 +: 8];
  endfunction

  task automatic restart_target();
    pat_pos     = 0;
    run_len     = 0;
    last_pos    = 0;
    tgt_len     = 0;
    acc_score   = 0;
    any_hit     = 1'b0;
    prefix_good = 1'b1;
    too_long    = 1'b0;
    prev_byte   = 8'h00;
  endtask

  // advance the match by one word and queue a score when the target ends
  task automatic fold_in_word(input logic [7:0] b, input logic eot, input logic emp);
    int          lim;
    int          at;
    int          gain;
    int          fin;
    logic [7:0]  lb;
    fss_result_t w;
    lim = (pat_len_q > 6'd32) ? 32 : int'(pat_len_q);
    if (!emp) begin
      at = tgt_len;
      lb = fold_case(b);
      if (tgt_len < 4095) tgt_len++;
      else too_long = 1'b1;
      if (at < lim && lb != fold_case(pat_char(at))) prefix_good = 1'b0;
      if (pat_pos < lim) begin
        if (lb == fold_case(pat_char(pat_pos))) begin
          gain = 10;
          if (at == 0) gain += 32;
          else if (word_break(prev_byte)) gain += 32;
          else if (b >= 8'h41 && b <= 8'h5A && prev_byte >= 8'h61 && prev_byte <= 8'h7A)
            gain += 24;
          gain += run_len * 16;
          // skipped bytes since the previous hit
          if (any_hit && at > last_pos + 1) gain -= (at - last_pos - 1) * 3;
          acc_score += gain;
          if (run_len < 63) run_len++;
          last_pos = at;
          any_hit  = 1'b1;
          pat_pos++;
        end else begin
          run_len = 0;
        end
      end
      prev_byte = b;
    end
    if (eot || emp) begin
      if (lim == 0) fin = 1000;
      else if (tgt_len == 0) fin = -10000;
      else if (lim > tgt_len) fin = -10000;
      else if (prefix_good && tgt_len == lim) fin = 10000 - tgt_len;
      else if (prefix_good) fin = 6000 - tgt_len;
      else if (pat_pos < lim) fin = -10000;
      else fin = acc_score - (tgt_len - lim);
      if (fin > 10000) fin = 10000;
      if (fin < -20000) fin = -20000;
      w.match_score     = 16'(fin);
      w.matched         = (fin > -10000);
      w.length_overflow = too_long;
      owed_scores.insert(owed_scores.size(), w);
      restart_target();
    end
  endtask

  task automatic check_word();
    fss_result_t w;
    if (owed_scores.size() == 0) begin
      $display("%0t: unexpected score word, expected none, got score %0d", $time,
               match_score_i);
      fail_count_o++;
      return;
    end
    w = owed_scores.pop_front();
    if (match_score_i !== w.match_score) begin
      $display("%0t: match_score expected %0d got %0d", $time, w.match_score, match_score_i);
      fail_count_o++;
    end
    if (matched_i !== w.matched) begin
      $display("%0t: matched expected %0b got %0b", $time, w.matched, matched_i);
      fail_count_o++;
    end
    if (length_overflow_i !== w.length_overflow) begin
      $display("%0t: length_overflow expected %0b got %0b", $time, w.length_overflow,
               length_overflow_i);
      fail_count_o++;
    end
  endtask

  // sample everything on the clock edge, before the drivers update
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q = '0;
      for (int i = 0; i < 4; i++) pat_word_q[i] = '0;
      restart_target();
      owed_scores.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PLEN: pat_len_q     = cfg_wdata_i[5:0];
          CFG_PAT0: pat_word_q[0] = cfg_wdata_i;
          CFG_PAT1: pat_word_q[1] = cfg_wdata_i;
          CFG_PAT2: pat_word_q[2] = cfg_wdata_i;
          CFG_PAT3: pat_word_q[3] = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) fold_in_word(target_byte_i, end_of_target_i, empty_target_i);
      if (out_valid_i && out_ready_i) check_word();
      pending_o = owed_scores.size();
    end
  end

endmodule

[tb/fuzzy_subsequence_score_unit_tb.sv]
`timescale 1ns / 1ps

module fuzzy_subsequence_score_unit_tb;
  import fss_pkg::*;

  localparam int SETTLE      = 4;
  localparam int HOLD_LEN    = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int SEG_WORDS   = 110;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [7:0]            tgt_byte  = 8'h00;
  logic                  tgt_end   = 1'b0;
  logic                  tgt_empty = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [15:0]    score;
  logic                  matched;
  logic                  len_ovf;

  int pending;
  int fail_count;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int rx_hold      = 0;
  int quiet        = 0;
  int words_sent   = 0;

  // pattern as programmed, used to build matching targets
  logic [7:0] pat_chr [PAT_BYTES];
  int         pat_eff = 0;

  always #2 clk = ~clk;

  fuzzy_subsequence_score_unit u_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .target_byte_i     (tgt_byte),
    .end_of_target_i   (tgt_end),
    .empty_target_i    (tgt_empty),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .match_score_o     (score),
    .matched_o         (matched),
    .length_overflow_o (len_ovf)
  );

  fuzzy_score_checker u_score_chk (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .target_byte_i     (tgt_byte),
    .end_of_target_i   (tgt_end),
    .empty_target_i    (tgt_empty),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .match_score_i     (score),
    .matched_i         (matched),
    .length_overflow_i (len_ovf),
    .pending_o         (pending),
    .fail_count_o      (fail_count)
  );

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold--;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // letters biased toward a few values so that hits are common
  function automatic logic [7:0] rand_char();
    logic [7:0] seps  [5];
    logic [7:0] edges [4];
    seps  = '{8'h20, 8'h2D, 8'h5F, 8'h2E, 8'h2F};
    edges = '{8'h40, 8'h5B, 8'h60, 8'h7B};
    case ($urandom_range(9))
      0, 1, 2: return 8'(8'h61 + $urandom_range(7));
      3:       return 8'(8'h61 + $urandom_range(25));
      4:       return 8'(8'h41 + $urandom_range(7));
      5:       return 8'(8'h41 + $urandom_range(25));
      6:       return seps[$urandom_range(4)];
      7:       return edges[$urandom_range(3)];
      8:       return 8'(8'h30 + $urandom_range(9));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) && $urandom_range(1))
      return c ^ 8'h20;
    return c;
  endfunction

  // offer one word, idling first at the sender's rate
  task automatic push_word(input logic [7:0] b, input logic e, input logic m);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    tgt_byte  <= b;
    tgt_end   <= e;
    tgt_empty <= m;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // stop offering until every score has come back and the pipe is empty
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // write all five registers, the length from len and the pattern from pat_chr
  task automatic load_pattern(input logic [5:0] len);
    logic [CFG_IDX_W-1:0] slot [4];
    logic [63:0]          w;
    slot = '{CFG_PAT0, CFG_PAT1, CFG_PAT2, CFG_PAT3};
    w = {$urandom(), $urandom()};
    w[5:0] = len;
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_PLEN;
    cfg_wdata <= w;
    @(posedge clk);
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 8; j++) w[j*8 +: 8] = pat_chr[k*8 + j];
      cfg_idx   <= slot[k];
      cfg_wdata <= w;
      @(posedge clk);
    end
    cfg_we  <= 1'b0;
    pat_eff = (len > 6'd32) ? 32 : int'(len);
  endtask

  task automatic set_text_pattern(input string s, input logic [5:0] len);
    for (int i = 0; i < PAT_BYTES; i++) pat_chr[i] = (i < s.len()) ? s[i] : rand_char();
    load_pattern(len);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) push_word(s[i], i == s.len() - 1, 1'b0);
  endtask

  // one target: mostly the pattern, whole or spread out with filler, some broken or noise
  task automatic send_target();
    logic [7:0] txt [$];
    int         kind;
    int         drop;
    kind = $urandom_range(19);
    if (kind <= 2) begin
      for (int i = 0; i < pat_eff; i++) txt.insert(txt.size(), flip_case(pat_chr[i]));
    end else if (kind <= 4) begin
      for (int i = 0; i < pat_eff; i++) txt.insert(txt.size(), flip_case(pat_chr[i]));
      repeat ($urandom_range(1, 6)) txt.insert(txt.size(), rand_char());
    end else if (kind <= 13) begin
      repeat ($urandom_range(2)) txt.insert(txt.size(), rand_char());
      for (int i = 0; i < pat_eff; i++) begin
        if ($urandom_range(2) == 0)
          repeat ($urandom_range(1, 4)) txt.insert(txt.size(), rand_char());
        txt.insert(txt.size(), flip_case(pat_chr[i]));
      end
      repeat ($urandom_range(3)) txt.insert(txt.size(), rand_char());
    end else if (kind <= 15) begin
      // one pattern byte replaced or left out
      drop = (pat_eff > 0) ? $urandom_range(pat_eff - 1) : 0;
      for (int i = 0; i < pat_eff; i++) begin
        if (i != drop) txt.insert(txt.size(), flip_case(pat_chr[i]));
        else if ($urandom_range(1)) txt.insert(txt.size(), rand_char());
      end
    end else if (kind <= 17) begin
      repeat ($urandom_range(12)) txt.insert(txt.size(), 8'($urandom_range(255)));
    end else if (kind == 18) begin
      for (int i = 0; i < $urandom_range(pat_eff); i++)
        txt.insert(txt.size(), flip_case(pat_chr[i]));
    end
    if (txt.size() == 0 || $urandom_range(4) == 0) begin
      // close with the empty marker, its byte and end flag are don't-care
      foreach (txt[i]) push_word(txt[i], 1'b0, 1'b0);
      push_word(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
    end else begin
      foreach (txt[i]) push_word(txt[i], i == txt.size() - 1, 1'b0);
    end
  endtask

  task automatic random_segment(input int words, input logic hold);
    int         start;
    logic [5:0] len;
    case ($urandom_range(9))
      0:       len = 6'd0;
      1:       len = 6'd1;
      2:       len = 6'd32;
      3:       len = 6'($urandom_range(33, 63));
      default: len = 6'($urandom_range(2, 8));
    endcase
    for (int i = 0; i < PAT_BYTES; i++) pat_chr[i] = rand_char();
    load_pattern(len);
    if (hold) rx_hold = HOLD_LEN;
    start = words_sent;
    while (words_sent - start < words) send_target();
  endtask

  initial begin
    logic [7:0] b;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty pattern after reset, with a byte target and a bare empty marker
    send_text("a");
    push_word(8'h00, 1'b0, 1'b1);

    // exact, prefix, short, empty, camel, separators, miss, marker close
    wait_drain();
    set_text_pattern("gEt", 6'd3);
    send_text("GET");
    send_text("getX");
    send_text("g");
    push_word(8'hA5, 1'b1, 1'b1);
    send_text("aGeT");
    send_text("x_g-e/t");
    send_text("gxx");
    send_text("xget");
    push_word(8'hFF, 1'b1, 1'b1);
    push_word(8'hFF, 1'b0, 1'b0);
    push_word(8'h00, 1'b1, 1'b0);
    send_text("[g@e`t{");

    // pattern rewritten in the middle of a target
    push_word("a", 1'b0, 1'b0);
    push_word("b", 1'b0, 1'b0);
    wait_drain();
    set_text_pattern("bcd", 6'd3);
    send_text("bcd");

    // length register above the cap, exact 32-byte target
    wait_drain();
    for (int i = 0; i < PAT_BYTES; i++) pat_chr[i] = 8'(8'h61 + $urandom_range(25));
    load_pattern(6'd63);
    for (int i = 0; i < PAT_BYTES; i++) push_word(flip_case(pat_chr[i]), i == PAT_BYTES - 1, 1'b0);

    // overlong target, hits both before and after the length saturates
    wait_drain();
    set_text_pattern("xYz", 6'd3);
    for (int i = 0; i < 4102; i++) begin
      if (i == 4000) b = "x";
      else if (i == 4097) b = "y";
      else if (i == 4100) b = "Z";
      else b = "q";
      push_word(b, i == 4101, 1'b0);
    end

    // random phases: receiver-heavy idling, sender-heavy, then none
    for (int p = 0; p < 3; p++) begin
      snd_idle_pct = (p == 0) ? 26 : (p == 1) ? 58 : 0;
      rcv_idle_pct = (p == 0) ? 58 : (p == 1) ? 26 : 0;
      for (int s = 0; s < 4; s++) begin
        wait_drain();
        random_segment(SEG_WORDS, p == 2 && s == 0);
      end
    end

    wait_drain();
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
